// File: hw/rtl/vpv_pkg.sv
// Shared constants, types and helper functions for the vertex projection pipeline.
package vpv_pkg;

   localparam int FRAC_BITS    = 12;
   localparam int MAX_VIEWPORT = 4096;

   localparam int IN_W    = 16;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 4 * COEF_W;
   localparam int PROD_W  = IN_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SUM_W   = ACC_W + 2;
   localparam int VIEW_W  = 13;
   localparam int SCALE_W = VIEW_W + 1;
   localparam int NUM_W   = SUM_W + SCALE_W;
   localparam int QW      = 16;
   localparam int DEN_W   = SUM_W;
   localparam int REM_W   = DEN_W + QW;
   localparam int PIX_W   = 12;
   localparam int DEPTH_W = 16;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_ROW3   = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QW-1:0]    q;
   } lane_type;

   typedef struct packed {
      lane_type         x;
      lane_type         y;
      lane_type         z;
      logic [DEN_W-1:0] den_xy;
      logic [DEN_W-1:0] den_z;
      logic             z_neg;
      logic             err;
   } div_type;

   // Zero reads as one, anything above the maximum reads as the maximum.
   function automatic logic [VIEW_W-1:0] view_eff(logic [VIEW_W-1:0] r);
      logic [VIEW_W-1:0] v;
      if (r == '0) begin
         v = VIEW_W'(1);
      end else if (r > VIEW_W'(MAX_VIEWPORT)) begin
         v = VIEW_W'(MAX_VIEWPORT);
      end else begin
         v = r;
      end
      return v;
   endfunction

   // Quotient saturates to all ones when it would not fit in QW bits.
   function automatic lane_type lane_init(logic [REM_W-1:0] n, logic [DEN_W-1:0] den);
      lane_type l;
      if (n >= (REM_W'(den) << QW)) begin
         l.rem = '0;
         l.q   = '1;
      end else begin
         l.rem = n;
         l.q   = '0;
      end
      return l;
   endfunction

   function automatic lane_type lane_step(lane_type l, logic [DEN_W-1:0] den, int unsigned sh);
      lane_type         o;
      logic [REM_W-1:0] dsh;
      o   = l;
      dsh = REM_W'(den) << sh;
      if (l.rem >= dsh) begin
         o.rem = l.rem - dsh;
         o.q   = l.q | (QW'(1) << sh);
      end
      return o;
   endfunction

   function automatic div_type div_step(div_type d, int unsigned sh);
      div_type o;
      o   = d;
      o.x = lane_step(d.x, d.den_xy, sh);
      o.y = lane_step(d.y, d.den_xy, sh);
      o.z = lane_step(d.z, d.den_z, sh);
      return o;
   endfunction

endpackage

// File: hw/rtl/vpv_ifs.sv
// Valid/ready channel interfaces for vertex input, pixel result and register writes.
interface vpv_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [vpv_pkg::IN_W-1:0]   vertex_x;
   logic signed [vpv_pkg::IN_W-1:0]   vertex_y;
   logic signed [vpv_pkg::IN_W-1:0]   vertex_z;
   modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                   output ready);
endinterface

interface vpv_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [vpv_pkg::PIX_W-1:0]          screen_x;
   logic [vpv_pkg::PIX_W-1:0]          screen_y;
   logic signed [vpv_pkg::DEPTH_W-1:0] ndc_depth;
   logic                               divide_error;
   modport source (output valid, output screen_x, output screen_y, output ndc_depth,
                   output divide_error, input ready);
   modport sink   (input valid, input screen_x, input screen_y, input ndc_depth,
                   input divide_error, output ready);
endinterface

interface vpv_csr_if;
   logic                                valid;
   logic                                ready;
   logic [vpv_pkg::CSR_IDX_W-1:0]       index;
   logic [vpv_pkg::ROW_W-1:0]           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/vpv_divider.sv
// Pipelined restoring divider, one quotient bit per stage for the three lanes.
module vpv_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  vpv_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output vpv_pkg::div_type out_data
);

   logic             v_ff  [vpv_pkg::QW];
   vpv_pkg::div_type d_ff  [vpv_pkg::QW];
   logic             v_src [vpv_pkg::QW];
   vpv_pkg::div_type d_src [vpv_pkg::QW];
   vpv_pkg::div_type d_in  [vpv_pkg::QW];
   logic             rdy   [vpv_pkg::QW+1];

   assign rdy[vpv_pkg::QW] = out_ready;
   assign v_src[0] = in_valid;
   assign d_src[0] = in_data;

   for (genvar g = 0; g < vpv_pkg::QW; g++) begin : g_stage
      if (g > 0) begin : g_link
         assign v_src[g] = v_ff[g-1];
         assign d_src[g] = d_ff[g-1];
      end
      assign rdy[g]  = ~v_ff[g] | rdy[g+1];
      assign d_in[g] = vpv_pkg::div_step(d_src[g], vpv_pkg::QW - 1 - g);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            v_ff[g] <= v_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g]) begin
            d_ff[g] <= d_in[g];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[vpv_pkg::QW-1];
   assign out_data  = d_ff[vpv_pkg::QW-1];

endmodule

// File: hw/rtl/vertex_project_viewport.sv
// Vertex transform, perspective divide and viewport mapping pipeline (top level).
// Takes one vertex per cycle and returns one result per vertex in order, registered in
// these stages: multiply, accumulate, w sign fold, viewport scale, divide setup, sixteen
// divider stages (one quotient bit each) and the output register. Each stage holds its
// item under backpressure while earlier bubbles close, so throughput is one vertex per
// cycle whenever the result side keeps up. The user must write registers through the csr
// channel only while no vertex is in flight; the block itself does not enforce this.
module vertex_project_viewport (
   input  logic  clock,
   input  logic  reset,
   vpv_req_if.sink   req_ch,
   vpv_rsp_if.source rsp_ch,
   vpv_csr_if.sink   csr_ch
);

   // configuration
   logic [vpv_pkg::ROW_W-1:0]  row_ff [4];
   logic [vpv_pkg::VIEW_W-1:0] width_ff;
   logic [vpv_pkg::VIEW_W-1:0] height_ff;
   logic [vpv_pkg::VIEW_W-1:0] wd_eff;
   logic [vpv_pkg::VIEW_W-1:0] ht_eff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) row_ff[r] <= '0;
         width_ff  <= vpv_pkg::VIEW_W'(640);
         height_ff <= vpv_pkg::VIEW_W'(480);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            vpv_pkg::CSR_ROW0:   row_ff[0] <= csr_ch.data;
            vpv_pkg::CSR_ROW1:   row_ff[1] <= csr_ch.data;
            vpv_pkg::CSR_ROW2:   row_ff[2] <= csr_ch.data;
            vpv_pkg::CSR_ROW3:   row_ff[3] <= csr_ch.data;
            vpv_pkg::CSR_WIDTH:  width_ff  <= csr_ch.data[vpv_pkg::VIEW_W-1:0];
            vpv_pkg::CSR_HEIGHT: height_ff <= csr_ch.data[vpv_pkg::VIEW_W-1:0];
            default: ;
         endcase
      end
   end

   assign wd_eff = vpv_pkg::view_eff(width_ff);
   assign ht_eff = vpv_pkg::view_eff(height_ff);

   // ready chain
   logic p_rdy, a_rdy, b_rdy, c_rdy, d_rdy, div_in_rdy, o_rdy;
   logic p_v_ff, a_v_ff, b_v_ff, c_v_ff, d_v_ff, o_v_ff;
   logic div_out_v;

   assign o_rdy = ~o_v_ff | rsp_ch.ready;
   assign d_rdy = ~d_v_ff | div_in_rdy;
   assign c_rdy = ~c_v_ff | d_rdy;
   assign b_rdy = ~b_v_ff | c_rdy;
   assign a_rdy = ~a_v_ff | b_rdy;
   assign p_rdy = ~p_v_ff | a_rdy;
   assign req_ch.ready = p_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (p_rdy) p_v_ff <= req_ch.valid;
         if (a_rdy) a_v_ff <= p_v_ff;
         if (b_rdy) b_v_ff <= a_v_ff;
         if (c_rdy) c_v_ff <= b_v_ff;
         if (d_rdy) d_v_ff <= c_v_ff;
         if (o_rdy) o_v_ff <= div_out_v;
      end
   end

   // products
   logic signed [vpv_pkg::IN_W-1:0]   vin [3];
   logic signed [vpv_pkg::PROD_W-1:0] prod_ff [4][3];
   logic signed [vpv_pkg::COEF_W-1:0] c3_ff [4];

   assign vin[0] = req_ch.vertex_x;
   assign vin[1] = req_ch.vertex_y;
   assign vin[2] = req_ch.vertex_z;

   always_ff @(posedge clock) begin
      if (p_rdy) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(row_ff[r][vpv_pkg::COEF_W*c +: vpv_pkg::COEF_W])
                                * vin[c];
            end
            c3_ff[r] <= $signed(row_ff[r][vpv_pkg::COEF_W*3 +: vpv_pkg::COEF_W]);
         end
      end
   end

   // accumulate
   logic signed [vpv_pkg::ACC_W-1:0] acc_ff [4];

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         for (int r = 0; r < 4; r++) begin
            acc_ff[r] <= vpv_pkg::ACC_W'(prod_ff[r][0]) + vpv_pkg::ACC_W'(prod_ff[r][1])
                       + vpv_pkg::ACC_W'(prod_ff[r][2])
                       + (vpv_pkg::ACC_W'(c3_ff[r]) <<< vpv_pkg::FRAC_BITS);
         end
      end
   end

   // fold the sign of w into the numerators
   logic signed [vpv_pkg::SUM_W-1:0] sum_x, sum_y, w_ext, z_ext;
   logic signed [vpv_pkg::SUM_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [vpv_pkg::DEN_W-1:0]        wabs_ff;
   logic                             b_err_ff;
   logic                             w_neg;

   assign w_ext = vpv_pkg::SUM_W'(acc_ff[3]);
   assign z_ext = vpv_pkg::SUM_W'(acc_ff[2]);
   assign sum_x = vpv_pkg::SUM_W'(acc_ff[0]) + w_ext;
   assign sum_y = vpv_pkg::SUM_W'(acc_ff[1]) + w_ext;
   assign w_neg = acc_ff[3][vpv_pkg::ACC_W-1];

   always_ff @(posedge clock) begin
      if (b_rdy) begin
         sx_ff    <= w_neg ? -sum_x : sum_x;
         sy_ff    <= w_neg ? -sum_y : sum_y;
         sz_ff    <= w_neg ? -z_ext : z_ext;
         wabs_ff  <= w_neg ? vpv_pkg::DEN_W'(-w_ext) : vpv_pkg::DEN_W'(w_ext);
         b_err_ff <= (acc_ff[3] == '0);
      end
   end

   // viewport scale
   logic signed [vpv_pkg::NUM_W-1:0] nx_ff, ny_ff;
   logic signed [vpv_pkg::SUM_W-1:0] cz_ff;
   logic [vpv_pkg::DEN_W-1:0]        c_wabs_ff;
   logic                             c_err_ff;

   always_ff @(posedge clock) begin
      if (c_rdy) begin
         nx_ff     <= sx_ff * $signed({1'b0, wd_eff});
         ny_ff     <= sy_ff * $signed({1'b0, ht_eff});
         cz_ff     <= sz_ff;
         c_wabs_ff <= wabs_ff;
         c_err_ff  <= b_err_ff;
      end
   end

   // divide setup
   vpv_pkg::div_type           d_in, d_ff, div_out;
   logic [vpv_pkg::DEN_W-1:0]  den_xy;
   logic [vpv_pkg::SUM_W-1:0]  z_mag;
   logic                       z_neg;

   assign den_xy = c_wabs_ff << 1;
   assign z_neg  = cz_ff[vpv_pkg::SUM_W-1];
   assign z_mag  = z_neg ? vpv_pkg::SUM_W'(-cz_ff) : vpv_pkg::SUM_W'(cz_ff);

   always_comb begin
      d_in.den_xy = den_xy;
      d_in.den_z  = c_wabs_ff;
      d_in.z_neg  = z_neg;
      d_in.err    = c_err_ff;
      d_in.x = vpv_pkg::lane_init(nx_ff[vpv_pkg::NUM_W-1] ? '0 :
                                  vpv_pkg::REM_W'(unsigned'(nx_ff)), den_xy);
      d_in.y = vpv_pkg::lane_init(ny_ff[vpv_pkg::NUM_W-1] ? '0 :
                                  vpv_pkg::REM_W'(unsigned'(ny_ff)), den_xy);
      d_in.z = vpv_pkg::lane_init(vpv_pkg::REM_W'(z_mag) << vpv_pkg::FRAC_BITS, c_wabs_ff);
   end

   always_ff @(posedge clock) begin
      if (d_rdy) begin
         d_ff <= d_in;
      end
   end

   vpv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_v_ff),
      .in_ready  (div_in_rdy),
      .in_data   (d_ff),
      .out_valid (div_out_v),
      .out_ready (o_rdy),
      .out_data  (div_out)
   );

   // clamp and format
   logic [vpv_pkg::PIX_W-1:0]          sx_in, sy_in, px_ff, py_ff;
   logic signed [vpv_pkg::DEPTH_W-1:0] dz_in, dz_ff;
   logic                               err_ff;
   logic [vpv_pkg::QW:0]               zt;

   always_comb begin
      zt = {1'b0, div_out.z.q} + vpv_pkg::QW'(div_out.z.rem != '0);
      if (div_out.x.q >= vpv_pkg::QW'(wd_eff)) begin
         sx_in = vpv_pkg::PIX_W'(wd_eff - 1'b1);
      end else begin
         sx_in = vpv_pkg::PIX_W'(div_out.x.q);
      end
      priority if (div_out.y.q >= vpv_pkg::QW'(ht_eff)) begin
         sy_in = '0;
      end else if (div_out.y.q == '0) begin
         sy_in = vpv_pkg::PIX_W'(ht_eff - 1'b1);
      end else begin
         sy_in = vpv_pkg::PIX_W'(vpv_pkg::QW'(ht_eff) - div_out.y.q);
      end
      if (div_out.z_neg) begin
         if (zt > (vpv_pkg::QW+1)'(32768)) begin
            dz_in = {1'b1, {(vpv_pkg::DEPTH_W-1){1'b0}}};
         end else begin
            dz_in = vpv_pkg::DEPTH_W'(-zt);
         end
      end else begin
         if (div_out.z.q > vpv_pkg::QW'(32767)) begin
            dz_in = {1'b0, {(vpv_pkg::DEPTH_W-1){1'b1}}};
         end else begin
            dz_in = vpv_pkg::DEPTH_W'(div_out.z.q);
         end
      end
      if (div_out.err) begin
         sx_in = '0;
         sy_in = '0;
         dz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy) begin
         px_ff  <= sx_in;
         py_ff  <= sy_in;
         dz_ff  <= dz_in;
         err_ff <= div_out.err;
      end
   end

   assign rsp_ch.valid        = o_v_ff;
   assign rsp_ch.screen_x     = px_ff;
   assign rsp_ch.screen_y     = py_ff;
   assign rsp_ch.ndc_depth    = dz_ff;
   assign rsp_ch.divide_error = err_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && err_ff |-> px_ff == '0 && py_ff == '0 && dz_ff == '0)
      else $error("zero w result carries nonzero fields");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !err_ff |-> {1'b0, px_ff} < wd_eff)
      else $error("screen_x outside viewport");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !err_ff |-> {1'b0, py_ff} < ht_eff)
      else $error("screen_y outside viewport");

   a_setup_hold: assert property (@(posedge clock) disable iff (reset)
      d_v_ff && !d_rdy |=> d_v_ff && $stable(d_ff))
      else $error("divide setup stage lost or changed a stalled item");
`endif

endmodule

// File: dv/vpv_checker.sv
// Checker: tracks register writes, predicts each vertex projection and compares results.
module vpv_checker (
   input  logic   clock,
   input  logic   reset,
   vpv_req_if     req_ch,
   vpv_rsp_if     rsp_ch,
   vpv_csr_if     csr_ch,
   output int     fail_count,
   output int     pending
);
   import vpv_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]          sx;
      logic [PIX_W-1:0]          sy;
      logic signed [DEPTH_W-1:0] depth;
      logic                      err;
   } pixel_type;

   logic [ROW_W-1:0]  mat_row [4];
   logic [VIEW_W-1:0] vp_w;
   logic [VIEW_W-1:0] vp_h;
   pixel_type         expected_q [$];

   function automatic longint fdiv(longint n, longint d);
      longint q;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic pixel_type project(logic signed [IN_W-1:0] vx,
                                         logic signed [IN_W-1:0] vy,
                                         logic signed [IN_W-1:0] vz);
      longint pt [4];
      longint acc [4];
      longint wd, ht, sx, sy, dz;
      logic signed [COEF_W-1:0] cf;
      pixel_type res;
      pt[0] = vx;
      pt[1] = vy;
      pt[2] = vz;
      pt[3] = longint'(1) << FRAC_BITS;
      for (int r = 0; r < 4; r++) begin
         acc[r] = 0;
         for (int c = 0; c < 4; c++) begin
            cf = mat_row[r][16*c +: 16];
            acc[r] += longint'(cf) * pt[c];
         end
      end
      res = '0;
      if (acc[3] == 0) begin
         res.err = 1'b1;
         return res;
      end
      wd = clip(vp_w, 1, MAX_VIEWPORT);
      ht = clip(vp_h, 1, MAX_VIEWPORT);
      sx = clip(fdiv((acc[0] + acc[3]) * wd, 2 * acc[3]), 0, wd - 1);
      sy = clip(ht - fdiv((acc[1] + acc[3]) * ht, 2 * acc[3]), 0, ht - 1);
      dz = clip(fdiv(acc[2] * (longint'(1) << FRAC_BITS), acc[3]), -32768, 32767);
      res.sx    = sx[PIX_W-1:0];
      res.sy    = sy[PIX_W-1:0];
      res.depth = dz[DEPTH_W-1:0];
      return res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) mat_row[i] <= '0;
         vp_w <= VIEW_W'(640);
         vp_h <= VIEW_W'(480);
         expected_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result transfer", rsp_ch.screen_x, -1);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.screen_x !== want.sx) report("screen_x", rsp_ch.screen_x, want.sx);
               if (rsp_ch.screen_y !== want.sy) report("screen_y", rsp_ch.screen_y, want.sy);
               if (rsp_ch.ndc_depth !== want.depth)
                  report("ndc_depth", rsp_ch.ndc_depth, want.depth);
               if (rsp_ch.divide_error !== want.err)
                  report("divide_error", rsp_ch.divide_error, want.err);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(project(req_ch.vertex_x, req_ch.vertex_y, req_ch.vertex_z));
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               CSR_ROW0, CSR_ROW1, CSR_ROW2, CSR_ROW3: begin
                  mat_row[csr_ch.index[1:0]] <= csr_ch.data;
               end
               CSR_WIDTH: begin
                  vp_w <= csr_ch.data[VIEW_W-1:0];
               end
               CSR_HEIGHT: begin
                  vp_h <= csr_ch.data[VIEW_W-1:0];
               end
               default: ;
            endcase
         end
      end
      pending <= expected_q.size();
   end

endmodule

// File: dv/tb_top.sv
// Testbench top: drives vertices, register writes and result backpressure, gives the verdict.
module tb_top;
   import vpv_pkg::*;

   localparam int  CYCLE_LIMIT = 300000;
   localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycles = 0;
   bit   quiet = 1'b0;
   bit   hold_req = 1'b0;

   vpv_req_if req_ch();
   vpv_rsp_if rsp_ch();
   vpv_csr_if csr_ch();

   vertex_project_viewport uut (.clock(clock), .reset(reset),
                                .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch));

   vpv_checker chk (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                    .csr_ch(csr_ch), .fail_count(fail_count), .pending(pending));

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.vertex_x = '0;
      req_ch.vertex_y = '0;
      req_ch.vertex_z = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_ROW0;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side backpressure, with one long hold-off on request
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            hold = 0;
            while (hold < 300) begin
               @(posedge clock);
               hold++;
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 12);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
      while (!quiet && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.vertex_x <= vx;
      req_ch.vertex_y <= vy;
      req_ch.vertex_z <= vz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_setup(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                             logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3,
                             logic [VIEW_W-1:0] w, logic [VIEW_W-1:0] h);
      csr_write(CSR_ROW0, r0);
      csr_write(CSR_ROW1, r1);
      csr_write(CSR_ROW2, r2);
      csr_write(CSR_ROW3, r3);
      csr_write(CSR_WIDTH, ROW_W'(w));
      csr_write(CSR_HEIGHT, ROW_W'(h));
   endtask

   function automatic logic [15:0] small_coef();
      return 16'($signed($urandom_range(2 * 8192)) - 8192);
   endfunction

   function automatic logic [ROW_W-1:0] rand_row(bit wild);
      if (wild) return {$urandom, $urandom};
      return {small_coef(), small_coef(), small_coef(), small_coef()};
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(2 * ONE)) - ONE);
         default: return 16'($signed($urandom_range(ONE / 2)) - ONE / 4);
      endcase
   endfunction

   function automatic logic [VIEW_W-1:0] rand_view();
      case ($urandom_range(5))
         0: return '0;
         1: return VIEW_W'(1);
         2: return VIEW_W'(MAX_VIEWPORT);
         3: return '1;
         4: return VIEW_W'($urandom_range(MAX_VIEWPORT + 1, 8191));
         default: return VIEW_W'($urandom_range(1, 2048));
      endcase
   endfunction

   initial begin
      logic [ROW_W-1:0] r3;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset matrix is all zero: every vertex is a divide error
      send_vertex(16'h7FFF, 16'h8000, 16'h0000);
      send_vertex(16'h1234, 16'hFFFF, 16'h8000);
      drain();

      // identity with w = 1: extremes of every field and pixel clamping
      load_setup({48'h0, ONE}, {32'h0, ONE, 16'h0}, {16'h0, ONE, 32'h0}, {ONE, 48'h0},
                 VIEW_W'(640), VIEW_W'(480));
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(16'h8000, 16'h8000, 16'h8000);
      send_vertex(ONE, ONE, ONE);
      send_vertex(-ONE, -ONE, -ONE);
      send_vertex(16'hFFFF, 16'h0001, 16'h5555);
      send_vertex(16'hAAAA, 16'h5555, 16'hAAAA);
      drain();
      csr_write(CSR_HEIGHT + 3'd1, '1);
      csr_write(CSR_HEIGHT + 3'd2, '1);

      // perspective: w = -z, zero z gives zero w; viewport at extremes
      load_setup({48'h0, ONE}, {32'h0, ONE, 16'h0}, {ONE, ONE, 32'h0},
                 {16'h0, 16'(-ONE), 32'h0}, VIEW_W'(MAX_VIEWPORT), '0);
      send_vertex(16'h0100, 16'hFF00, 16'h0000);
      send_vertex(16'h0100, 16'hFF00, -ONE);
      send_vertex(16'h7FFF, 16'h8000, 16'h0001);
      send_vertex(16'h0800, 16'h0800, 16'hFFFF);
      send_vertex(16'h8000, 16'h7FFF, 16'h8000);
      send_vertex(16'h0000, 16'h0000, 16'h7FFF);
      drain();
      load_setup({48'h0, ONE}, {32'h0, ONE, 16'h0}, {16'h0, ONE, 32'h0},
                 {48'h0, 16'h0001}, '1, VIEW_W'(1));
      send_vertex(16'h0001, 16'hFFFF, 16'h7FFF);
      send_vertex(16'h8000, 16'h7FFF, 16'h8000);
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         r3 = rand_row(ph % 4 == 3);
         if (ph % 3 == 1) r3[15:0] = 16'h0;
         load_setup(rand_row(ph % 4 == 3), rand_row(ph % 4 == 3), rand_row(ph % 4 == 3),
                    r3, rand_view(), rand_view());
         quiet = (ph == 2);
         if (ph == 4) hold_req = 1'b1;
         for (int i = 0; i < 75; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
         drain();
      end
      quiet = 1'b0;

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: vertex_project_viewport.f
hw/rtl/vpv_pkg.sv
hw/rtl/vpv_ifs.sv
hw/rtl/vpv_divider.sv
hw/rtl/vertex_project_viewport.sv
dv/vpv_checker.sv
dv/tb_top.sv
